[rtl/terminal_parameter_string_expander_assert.svh]
// Assertion helpers for the string expander checker.
`ifndef TERMINAL_PARAMETER_STRING_EXPANDER_ASSERT_SVH
`define TERMINAL_PARAMETER_STRING_EXPANDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPSE_AST_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPSE_AST_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tpse_pkg.sv]
`default_nettype none
package tpse_pkg;

   // Format characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_UC    = 8'h43;
   localparam logic [7:0] CH_UD    = 8'h44;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LD    = 8'h64;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LI    = 8'h69;
   localparam logic [7:0] CH_LM    = 8'h6D;
   localparam logic [7:0] CH_LN    = 8'h6E;
   localparam logic [7:0] CH_LP    = 8'h70;
   localparam logic [7:0] CH_LR    = 8'h72;

   // Argument masks for %n and %m
   localparam logic [7:0] XOR_N = 8'h60;
   localparam logic [7:0] XOR_M = 8'h7F;

   // Decimal clamp and divisors
   localparam logic [16:0] DEC_MAX  = 17'd99999;
   localparam logic [7:0]  DIV_TEN  = 8'd10;
   localparam logic [7:0]  DIV_C    = 8'd96;
   localparam int          NUM_ARGS = 4;
   localparam int          CFG_W    = 16;
   localparam int          DEC_DIGS = 5;

   // Reciprocals for constant division of values below 2^32
   // x/10 = (x * RECIP_TEN) >> 35, x/3 = (x * RECIP_THREE) >> 33
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam logic [31:0] RECIP_THREE = 32'hAAAA_AAAB;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ADV,
      OP_BACK,
      OP_INC01,
      OP_SWAP01,
      OP_XORN,
      OP_XORM,
      OP_SETB,
      OP_SETD,
      OP_GT,
      OP_APPLY,
      OP_SETDIV,
      OP_HOLD_OP,
      OP_HOLD_KIND,
      OP_CLR_HELD,
      OP_DEC_INIT,
      OP_DEC_PUSH,
      OP_DEC_SETE
   } dp_op_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_BYTE,
      EM_PCT,
      EM_TLOW,
      EM_TPLUSB,
      EM_QUOT,
      EM_DIGIT,
      EM_TERM
   } em_type;

   typedef enum logic [1:0] {
      DV_B,
      DV_A,
      DV_C,
      DV_DEC
   } dv_type;

   typedef struct packed {
      logic      latch;
      dp_op_type op;
      em_type    emit;
      logic      flush;
      logic      div_start;
      dv_type    div_sel;
   } cmd_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_end;
      logic [7:0] held_op;
      logic       div_busy;
      logic       t_ge96;
      logic       dec_more;
      logic       e_last;
      logic       out_free;
   } stat_type;

endpackage
`default_nettype wire

[rtl/terminal_parameter_string_expander.sv]
`default_nettype none
// Expands a terminal capability format string, one format byte per transaction,
// into control bytes, one result per transaction on the rsp_ side, the last result
// of each input flagged by rsp_run_last and the closing NUL by rsp_is_terminator.
// The four argument registers are sampled when the first byte of a string is
// taken. One input is in flight at a time. An echoed unknown escape, %B and %C
// with an argument of 96 or more take extra steps; %d/%2/%3 divide once per
// digit converted, then size the field and print each digit in turn. Constant
// divisions use reciprocal multiplies; only %a with '/' runs on the
// one-bit-per-cycle divider. A stalled result in the output register of the
// two-deep result stage holds the sequencer.
module terminal_parameter_string_expander #(
   parameter int ARG_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_format_byte,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_is_terminator,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tpse_pkg::*;

   logic [NUM_ARGS-1:0][CFG_W-1:0] cfg_ff;
   cmd_type  cmd;
   stat_type stat;

   // Argument registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (psel && penable && pwrite) begin
         cfg_ff[paddr[3:2]] <= pwdata[CFG_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = 32'(cfg_ff[paddr[3:2]]);

   tpse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpse_datapath #(
      .AW (ARG_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .in_byte           (req_format_byte),
      .in_end            (req_string_end),
      .cfg_args          (cfg_ff),
      .rsp_stall         (rsp_stall),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_is_terminator (rsp_is_terminator)
   );

endmodule
`default_nettype wire

[rtl/tpse_datapath.sv]
`default_nettype none
module tpse_datapath #(
   parameter int AW = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tpse_pkg::cmd_type                       cmd,
   input  logic [7:0]                              in_byte,
   input  logic                                    in_end,
   input  logic [tpse_pkg::NUM_ARGS-1:0][tpse_pkg::CFG_W-1:0] cfg_args,
   input  logic                                    rsp_stall,
   output tpse_pkg::stat_type                      stat,
   output logic                                    rsp_valid,
   output logic [7:0]                              rsp_out_byte,
   output logic                                    rsp_run_last,
   output logic                                    rsp_is_terminator
);
   import tpse_pkg::*;

   localparam int DVW = (AW > 17) ? AW : 17;
   localparam int CW  = $clog2(DVW + 1);

   // Item and argument state
   logic [7:0]    byte_ff;
   logic          end_ff;
   logic [AW-1:0] arg_ff [NUM_ARGS];
   logic [AW-1:0] arg_in [NUM_ARGS];
   logic [1:0]    ptr_ff, ptr_in;
   logic [7:0]    hop_ff, hop_in;
   logic [7:0]    hkind_ff, hkind_in;

   // Divider state
   logic [DVW-1:0] rem_ff, quo_ff, dvs_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           neg_ff;

   // Decimal state
   logic [DVW-1:0] dec_ff;
   logic [3:0]     dig_ff [DEC_DIGS];
   logic [2:0]     n_ff;
   logic [1:0]     minw_ff;
   logic [2:0]     e_ff;

   // Result staging
   logic       pend_valid_ff;
   logic [7:0] pend_byte_ff;
   logic       pend_term_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_term_ff;

   logic [AW-1:0]   t, val, t_mag, val_mag, sq, prod_lo, sq6;
   logic [2*AW-1:0] prod;
   logic [3:0]      r4;
   logic [DVW-1:0]  dvd_sel, dvs_sel;
   logic            neg_sel;
   logic [DVW:0]    shifted, diff;
   logic [31:0]     dvd32;
   logic [63:0]     m10, m3;
   logic [DVW-1:0]  q10, r10, q96;
   logic [32:0]     t_wide;
   logic [DVW-1:0]  dec_init;
   logic [2:0]      didx;
   logic [7:0]      digit_byte;
   logic [7:0]      new_byte;
   logic            new_term;
   logic            out_free;

   assign t      = arg_ff[ptr_ff];
   assign t_mag  = t[AW-1] ? (~t + 1'b1) : t;
   assign val    = (hkind_ff == CH_LP) ? arg_ff[byte_ff[1:0]] : AW'(byte_ff[6:0]);
   assign val_mag = val[AW-1] ? (~val + 1'b1) : val;
   assign prod   = t * val;
   assign prod_lo = prod[AW-1:0];
   assign sq     = neg_ff ? (~quo_ff[AW-1:0] + 1'b1) : quo_ff[AW-1:0];
   assign sq6    = (sq << 2) + (sq << 1);
   assign r4     = t_mag[3:0];
   assign t_wide = 33'(t);
   assign dec_init = t[AW-1] ? '0 :
                     (t_wide > 33'(DEC_MAX)) ? DVW'(DEC_MAX) : DVW'(t);

   // Divider operand select
   always_comb begin
      dvd_sel = DVW'(t_mag);
      dvs_sel = DVW'(DIV_TEN);
      neg_sel = 1'b0;
      case (cmd.div_sel)
         DV_B: begin
            neg_sel = t[AW-1];
         end
         DV_A: begin
            dvs_sel = (val == '0) ? DVW'(1'b1) : DVW'(val_mag);
            neg_sel = t[AW-1] ^ val[AW-1];
         end
         DV_C: begin
            dvd_sel = DVW'(t);
            dvs_sel = DVW'(DIV_C);
         end
         DV_DEC: begin
            dvd_sel = dec_ff;
         end
         default: begin
            neg_sel = 1'b0;
         end
      endcase
   end

   // Constant divisors by reciprocal multiply; 96 is 32 times 3
   assign dvd32 = 32'(dvd_sel);
   assign m10   = 64'(dvd32) * 64'(RECIP_TEN);
   assign q10   = DVW'(m10[63:35]);
   assign r10   = dvd_sel - ((q10 << 3) + (q10 << 1));
   assign m3    = 64'(dvd32 >> 5) * 64'(RECIP_THREE);
   assign q96   = DVW'(m3[63:33]);

   // Restoring division step, used for %a division only
   assign shifted = {rem_ff, quo_ff[DVW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         cnt_ff  <= CW'(DVW);
         dvs_ff  <= dvs_sel;
         neg_ff  <= neg_sel;
         if (cmd.div_sel == DV_A) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            quo_ff  <= dvd_sel;
         end else if (cmd.div_sel == DV_C) begin
            busy_ff <= 1'b0;
            rem_ff  <= '0;
            quo_ff  <= q96;
         end else begin
            busy_ff <= 1'b0;
            rem_ff  <= r10;
            quo_ff  <= q10;
         end
      end else if (busy_ff) begin
         if (!diff[DVW]) begin
            rem_ff <= diff[DVW-1:0];
         end else begin
            rem_ff <= shifted[DVW-1:0];
         end
         quo_ff  <= {quo_ff[DVW-2:0], ~diff[DVW]};
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CW'(1));
      end
   end

   // Argument file, pointer and held bytes
   always_comb begin
      for (int i = 0; i < NUM_ARGS; i++) begin
         arg_in[i] = arg_ff[i];
      end
      ptr_in   = ptr_ff;
      hop_in   = hop_ff;
      hkind_in = hkind_ff;
      case (cmd.op)
         OP_LOAD: begin
            for (int i = 0; i < NUM_ARGS; i++) begin
               arg_in[i] = AW'($signed(cfg_args[i]));
            end
            ptr_in   = '0;
            hop_in   = '0;
            hkind_in = '0;
         end
         OP_ADV: begin
            if (ptr_ff != 2'd3) ptr_in = ptr_ff + 1'b1;
         end
         OP_BACK: begin
            if (ptr_ff != 2'd0) ptr_in = ptr_ff - 1'b1;
         end
         OP_INC01: begin
            arg_in[0] = arg_ff[0] + 1'b1;
            arg_in[1] = arg_ff[1] + 1'b1;
         end
         OP_SWAP01: begin
            arg_in[0] = arg_ff[1];
            arg_in[1] = arg_ff[0];
         end
         OP_XORN: begin
            arg_in[0] = arg_ff[0] ^ AW'(XOR_N);
            arg_in[1] = arg_ff[1] ^ AW'(XOR_N);
         end
         OP_XORM: begin
            arg_in[0] = arg_ff[0] ^ AW'(XOR_M);
            arg_in[1] = arg_ff[1] ^ AW'(XOR_M);
         end
         OP_SETB: begin
            arg_in[ptr_ff] = t + sq6;
         end
         OP_SETD: begin
            // truncating remainder keeps the sign of the argument
            if (t[AW-1]) arg_in[ptr_ff] = t + AW'({r4, 1'b0});
            else arg_in[ptr_ff] = t - AW'({r4, 1'b0});
         end
         OP_GT: begin
            if ($signed(33'($signed(t))) > $signed(33'(hop_ff))) begin
               arg_in[ptr_ff] = t + AW'(byte_ff);
            end
         end
         OP_APPLY: begin
            case (hop_ff)
               CH_MINUS: arg_in[ptr_ff] = t - val;
               CH_PLUS:  arg_in[ptr_ff] = t + val;
               CH_STAR:  arg_in[ptr_ff] = prod_lo;
               default:  arg_in[ptr_ff] = val;
            endcase
         end
         OP_SETDIV: begin
            arg_in[ptr_ff] = sq;
         end
         OP_HOLD_OP: begin
            hop_in = byte_ff;
         end
         OP_HOLD_KIND: begin
            hkind_in = byte_ff;
         end
         OP_CLR_HELD: begin
            hop_in   = '0;
            hkind_in = '0;
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ARGS; i++) begin
            arg_ff[i] <= '0;
         end
         ptr_ff   <= '0;
         hop_ff   <= '0;
         hkind_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_ARGS; i++) begin
            arg_ff[i] <= arg_in[i];
         end
         ptr_ff   <= ptr_in;
         hop_ff   <= hop_in;
         hkind_ff <= hkind_in;
      end
   end

   // Input capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff <= in_byte;
         end_ff  <= in_end;
      end
   end

   // Decimal digit collection, least significant first
   assign didx       = e_ff - 1'b1;
   assign digit_byte = (didx >= n_ff) ? CH_ZERO : (CH_ZERO + 8'(dig_ff[didx]));

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         e_ff    <= '0;
         minw_ff <= 2'd1;
      end else begin
         case (cmd.op)
            OP_DEC_INIT: begin
               dec_ff  <= dec_init;
               n_ff    <= '0;
               minw_ff <= (byte_ff == CH_TWO) ? 2'd2 :
                          (byte_ff == CH_THREE) ? 2'd3 : 2'd1;
            end
            OP_DEC_PUSH: begin
               dig_ff[n_ff] <= rem_ff[3:0];
               n_ff         <= n_ff + 1'b1;
               dec_ff       <= quo_ff;
            end
            OP_DEC_SETE: begin
               e_ff <= (n_ff < 3'(minw_ff)) ? 3'(minw_ff) : n_ff;
            end
            default: begin
               if (cmd.emit == EM_DIGIT) e_ff <= didx;
            end
         endcase
      end
   end

   // Result byte select
   always_comb begin
      new_term = 1'b0;
      case (cmd.emit)
         EM_BYTE:   new_byte = byte_ff;
         EM_PCT:    new_byte = CH_PCT;
         EM_TLOW:   new_byte = t[7:0];
         EM_TPLUSB: new_byte = t[7:0] + byte_ff;
         EM_QUOT:   new_byte = quo_ff[7:0];
         EM_DIGIT:  new_byte = digit_byte;
         EM_TERM: begin
            new_byte = CH_NUL;
            new_term = 1'b1;
         end
         default:   new_byte = CH_NUL;
      endcase
   end

   // One result is held back so the last one of an item can be flagged
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.emit != EM_NONE) begin
            pend_valid_ff <= 1'b1;
            pend_byte_ff  <= new_byte;
            pend_term_ff  <= new_term;
            if (pend_valid_ff) begin
               out_valid_ff <= 1'b1;
               out_byte_ff  <= pend_byte_ff;
               out_term_ff  <= pend_term_ff;
               out_last_ff  <= 1'b0;
            end else if (out_valid_ff && !rsp_stall) begin
               out_valid_ff <= 1'b0;
            end
         end else if (cmd.flush && pend_valid_ff) begin
            pend_valid_ff <= 1'b0;
            out_valid_ff  <= 1'b1;
            out_byte_ff   <= pend_byte_ff;
            out_term_ff   <= pend_term_ff;
            out_last_ff   <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_run_last      = out_last_ff;
   assign rsp_is_terminator = out_term_ff;

   // Status to controller
   assign stat.in_byte  = byte_ff;
   assign stat.in_end   = end_ff;
   assign stat.held_op  = hop_ff;
   assign stat.div_busy = busy_ff;
   assign stat.t_ge96   = !t[AW-1] && (t >= AW'(DIV_C));
   assign stat.dec_more = (quo_ff != '0) && (n_ff < 3'd4);
   assign stat.e_last   = (e_ff == 3'd1);
   assign stat.out_free = out_free;

endmodule
`default_nettype wire

[rtl/tpse_ctrl.sv]
`default_nettype none
module tpse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tpse_pkg::stat_type stat,
   output tpse_pkg::cmd_type  cmd
);
   import tpse_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_PROC, S_ECHO, S_BDIV, S_ADIV, S_CDIV, S_CADD2,
      S_DSTART, S_DDIV, S_DPAD, S_DOUT, S_END, S_FLUSH
   } state_type;

   typedef enum logic [3:0] {
      PH_START, PH_LIT, PH_PCT, PH_PLUS, PH_GT1, PH_GT2,
      PH_AOP, PH_AKIND, PH_AVAL, PH_CADD
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_START;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cmd.latch     = 1'b0;
      cmd.op        = OP_NONE;
      cmd.emit      = EM_NONE;
      cmd.flush     = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DV_B;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (phase_ff == PH_START) begin
                  cmd.op   = OP_LOAD;
                  phase_in = PH_LIT;
               end
               state_in = S_PROC;
            end
         end
         S_PROC: begin
            if (stat.out_free) begin
               state_in = S_END;
               if (stat.in_byte != CH_NUL) begin
                  case (phase_ff)
                     PH_LIT: begin
                        if (stat.in_byte == CH_PCT) phase_in = PH_PCT;
                        else cmd.emit = EM_BYTE;
                     end
                     PH_PCT: begin
                        phase_in = PH_LIT;
                        case (stat.in_byte)
                           CH_PCT: cmd.emit = EM_PCT;
                           CH_LD, CH_TWO, CH_THREE: begin
                              cmd.op   = OP_DEC_INIT;
                              state_in = S_DSTART;
                           end
                           CH_DOT: begin
                              cmd.emit = EM_TLOW;
                              cmd.op   = OP_ADV;
                           end
                           CH_PLUS: phase_in = PH_PLUS;
                           CH_GT:   phase_in = PH_GT1;
                           CH_LA:   phase_in = PH_AOP;
                           CH_UC:   phase_in = PH_CADD;
                           CH_LI:   cmd.op = OP_INC01;
                           CH_LR:   cmd.op = OP_SWAP01;
                           CH_LN:   cmd.op = OP_XORN;
                           CH_LM:   cmd.op = OP_XORM;
                           CH_UB: begin
                              cmd.div_start = 1'b1;
                              cmd.div_sel   = DV_B;
                              state_in      = S_BDIV;
                           end
                           CH_UD:   cmd.op = OP_SETD;
                           CH_LF:   cmd.op = OP_ADV;
                           CH_LB:   cmd.op = OP_BACK;
                           default: begin
                              // unknown escape is echoed
                              cmd.emit = EM_PCT;
                              state_in = S_ECHO;
                           end
                        endcase
                     end
                     PH_PLUS: begin
                        cmd.emit = EM_TPLUSB;
                        cmd.op   = OP_ADV;
                        phase_in = PH_LIT;
                     end
                     PH_GT1: begin
                        cmd.op   = OP_HOLD_OP;
                        phase_in = PH_GT2;
                     end
                     PH_GT2: begin
                        cmd.op   = OP_GT;
                        phase_in = PH_LIT;
                     end
                     PH_AOP: begin
                        cmd.op   = OP_HOLD_OP;
                        phase_in = PH_AKIND;
                     end
                     PH_AKIND: begin
                        cmd.op   = OP_HOLD_KIND;
                        phase_in = PH_AVAL;
                     end
                     PH_AVAL: begin
                        phase_in = PH_LIT;
                        if (stat.held_op == CH_SLASH) begin
                           cmd.div_start = 1'b1;
                           cmd.div_sel   = DV_A;
                           state_in      = S_ADIV;
                        end else begin
                           cmd.op = OP_APPLY;
                        end
                     end
                     PH_CADD: begin
                        phase_in = PH_LIT;
                        if (stat.t_ge96) begin
                           cmd.div_start = 1'b1;
                           cmd.div_sel   = DV_C;
                           state_in      = S_CDIV;
                        end else begin
                           cmd.emit = EM_TPLUSB;
                           cmd.op   = OP_ADV;
                        end
                     end
                     default: phase_in = PH_LIT;
                  endcase
               end
            end
         end
         S_ECHO: begin
            if (stat.out_free) begin
               cmd.emit = EM_BYTE;
               state_in = S_END;
            end
         end
         S_BDIV: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_SETB;
               state_in = S_END;
            end
         end
         S_ADIV: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_SETDIV;
               state_in = S_END;
            end
         end
         S_CDIV: begin
            if (!stat.div_busy && stat.out_free) begin
               cmd.emit = EM_QUOT;
               state_in = S_CADD2;
            end
         end
         S_CADD2: begin
            if (stat.out_free) begin
               cmd.emit = EM_TPLUSB;
               cmd.op   = OP_ADV;
               state_in = S_END;
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DV_DEC;
            state_in      = S_DDIV;
         end
         S_DDIV: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_DEC_PUSH;
               state_in = stat.dec_more ? S_DSTART : S_DPAD;
            end
         end
         S_DPAD: begin
            cmd.op   = OP_DEC_SETE;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            if (stat.out_free) begin
               cmd.emit = EM_DIGIT;
               if (stat.e_last) begin
                  cmd.op   = OP_ADV;
                  state_in = S_END;
               end
            end
         end
         S_END: begin
            if (stat.out_free) begin
               if (stat.in_end || stat.in_byte == CH_NUL) begin
                  cmd.emit = EM_TERM;
                  cmd.op   = OP_CLR_HELD;
                  phase_in = PH_START;
               end
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[rtl/tpse_checker.sv]
`default_nettype none
`include "terminal_parameter_string_expander_assert.svh"
module tpse_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_is_terminator
);
   // stalled result holds
   `TPSE_AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte), "stalled result changed")
   // the terminator closes the input's results
   `TPSE_AST_SAME(a_term_last, clock, reset, rsp_valid && rsp_is_terminator, rsp_run_last, "terminator not last")
   // the terminator is a NUL
   `TPSE_AST_SAME(a_term_nul, clock, reset, rsp_valid && rsp_is_terminator, rsp_out_byte == 8'h00, "terminator not NUL")
   // one item in flight: after taking an item the input stalls
   `TPSE_AST_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "second item taken back to back")
endmodule

bind terminal_parameter_string_expander tpse_props u_tpse_props (.*);
`default_nettype wire
